### rtl/ipv4l4_pkg.sv
// Package for the IPv4 / TCP / UDP header parser.
// Holds the result status codes and the protocol and header constants.
// No dependencies.
`default_nettype none

package ipv4l4_pkg;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_NOT_V4       = 3'd1,
        ST_IHL_SMALL    = 3'd2,
        ST_LEN_MISMATCH = 3'd3,
        ST_TCP_SHORT    = 3'd4,
        ST_TCP_NEG      = 3'd5,
        ST_UDP_SHORT    = 3'd6,
        ST_UDP_NEG      = 3'd7
    } status_t;

    localparam logic [7:0]  PROTO_TCP     = 8'd6;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;
    localparam logic [3:0]  IP_VERSION_4  = 4'h4;
    localparam logic [3:0]  IHL_MIN       = 4'd5;
    localparam logic [6:0]  TCP_HDR_MIN   = 7'd20;
    localparam logic [6:0]  UDP_HDR_LEN   = 7'd8;
    localparam logic [15:0] POS_MAX       = 16'hFFFF;

    localparam logic [15:0] POS_VER_IHL   = 16'd0;
    localparam logic [15:0] POS_LEN_HI    = 16'd2;
    localparam logic [15:0] POS_LEN_LO    = 16'd3;
    localparam logic [15:0] POS_PROTO     = 16'd9;
    localparam logic [15:0] POS_SRC_FIRST = 16'd12;
    localparam logic [15:0] POS_SRC_LAST  = 16'd15;
    localparam logic [15:0] POS_DST_FIRST = 16'd16;
    localparam logic [15:0] POS_DST_LAST  = 16'd19;
    localparam logic [16:0] L4_PORT_BYTES = 17'd4;
    localparam logic [16:0] L4_OFF_BYTE   = 17'd12;
    localparam logic [16:0] L4_FLAG_BYTE  = 17'd13;
    localparam logic [16:0] COUNT_MIN     = 17'd4;

endpackage

`default_nettype wire

### rtl/ipv4_l4_header_parser_core.sv
// IPv4 / TCP / UDP header parser, top level.
// Captures header fields from a byte stream and emits one result per packet.
// Depends on ipv4l4_pkg.
`default_nettype none

// The block takes one packet byte per clock, starting at IPv4 header byte 0,
// with end_of_packet on the final byte. Every other byte only updates captured
// header registers; the final byte's transfer computes the result in the same
// cycle, loads it into the output register and clears the capture, so a result
// appears in the cycle after the last byte and the next packet may start in the
// cycle right after. Throughput is one byte per cycle; input is held only when a
// final byte arrives while an earlier result is still waiting and stalled.
// Rejected headers (status 1 to 3) give all other result fields as zero.
module ipv4_l4_header_parser_core (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        data_valid,
    output logic             data_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        end_of_packet,

    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [2:0]       status,
    output logic [31:0]      source_address,
    output logic [31:0]      dest_address,
    output logic [7:0]       protocol_number,
    output logic [15:0]      source_port,
    output logic [15:0]      dest_port,
    output logic [16:0]      payload_length,
    output logic [5:0]       ip_header_length,
    output logic [5:0]       l4_header_length,
    output logic [7:0]       tcp_flag_bits
);

    logic [15:0] pos_reg,    pos_next;
    logic [7:0]  vihl_reg,   vihl_next;
    logic [15:0] tlen_reg,   tlen_next;
    logic [7:0]  proto_reg,  proto_next;
    logic [31:0] src_reg,    src_next;
    logic [31:0] dst_reg,    dst_next;
    logic [31:0] ports_reg,  ports_next;
    logic [15:0] offfl_reg,  offfl_next;

    logic        rvalid_reg, rvalid_next;
    logic [2:0]  status_reg, status_next;
    logic [31:0] rsrc_reg,   rsrc_next;
    logic [31:0] rdst_reg,   rdst_next;
    logic [7:0]  rproto_reg, rproto_next;
    logic [15:0] rsport_reg, rsport_next;
    logic [15:0] rdport_reg, rdport_next;
    logic [16:0] rpay_reg,   rpay_next;
    logic [5:0]  rihl_reg,   rihl_next;
    logic [5:0]  rl4_reg,    rl4_next;
    logic [7:0]  rflags_reg, rflags_next;

    logic        take;
    logic        finish;
    logic [5:0]  off;
    logic [16:0] pos_ext;
    logic [16:0] off_ext;
    logic [16:0] diff;
    logic [16:0] count;
    logic [16:0] tlen_ext;
    logic [5:0]  l4len;
    logic [16:0] tcp_min;
    logic [16:0] tcp_need;
    logic [16:0] udp_min;
    ipv4l4_pkg::status_t st;

    assign data_stall = rvalid_reg && result_stall && end_of_packet;
    assign take       = data_valid && !data_stall;
    assign finish     = take && end_of_packet;

    // Capture header bytes
    always_comb
    begin
        vihl_next  = vihl_reg;
        tlen_next  = tlen_reg;
        proto_next = proto_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        ports_next = ports_reg;
        offfl_next = offfl_reg;
        pos_next   = pos_reg;
        pos_ext    = {1'b0, pos_reg};

        if (pos_reg == ipv4l4_pkg::POS_VER_IHL)
        begin
            vihl_next = data_byte;
        end
        if (pos_reg == ipv4l4_pkg::POS_LEN_HI)
        begin
            tlen_next[15:8] = data_byte;
        end
        if (pos_reg == ipv4l4_pkg::POS_LEN_LO)
        begin
            tlen_next[7:0] = data_byte;
        end
        if (pos_reg == ipv4l4_pkg::POS_PROTO)
        begin
            proto_next = data_byte;
        end
        if (pos_reg >= ipv4l4_pkg::POS_SRC_FIRST && pos_reg <= ipv4l4_pkg::POS_SRC_LAST)
        begin
            src_next[{~pos_reg[1:0], 3'b000} +: 8] = data_byte;
        end
        if (pos_reg >= ipv4l4_pkg::POS_DST_FIRST && pos_reg <= ipv4l4_pkg::POS_DST_LAST)
        begin
            dst_next[{~pos_reg[1:0], 3'b000} +: 8] = data_byte;
        end

        off     = {vihl_next[3:0], 2'b00};
        off_ext = {11'd0, off};
        diff    = pos_ext - off_ext;
        if (pos_ext >= off_ext && pos_ext < off_ext + ipv4l4_pkg::L4_PORT_BYTES)
        begin
            ports_next[{~diff[1:0], 3'b000} +: 8] = data_byte;
        end
        if (pos_ext == off_ext + ipv4l4_pkg::L4_OFF_BYTE)
        begin
            offfl_next[15:8] = data_byte;
        end
        if (pos_ext == off_ext + ipv4l4_pkg::L4_FLAG_BYTE)
        begin
            offfl_next[7:0] = data_byte;
        end

        if (pos_reg != ipv4l4_pkg::POS_MAX)
        begin
            pos_next = pos_reg + 16'd1;
        end
    end

    // Build the result from the updated capture
    always_comb
    begin
        count    = pos_ext + 17'd1;
        tlen_ext = {1'b0, tlen_next};
        l4len    = {offfl_next[15:12], 2'b00};
        tcp_min  = off_ext + {10'd0, ipv4l4_pkg::TCP_HDR_MIN};
        tcp_need = off_ext + {11'd0, l4len};
        udp_min  = off_ext + {10'd0, ipv4l4_pkg::UDP_HDR_LEN};

        st          = ipv4l4_pkg::ST_OK;
        rsrc_next   = src_next;
        rdst_next   = dst_next;
        rproto_next = proto_next;
        rsport_next = 16'd0;
        rdport_next = 16'd0;
        rpay_next   = tlen_ext - off_ext;
        rihl_next   = off;
        rl4_next    = 6'd0;
        rflags_next = 8'd0;

        if (vihl_next[7:4] != ipv4l4_pkg::IP_VERSION_4)
        begin
            st = ipv4l4_pkg::ST_NOT_V4;
        end
        else if (vihl_next[3:0] < ipv4l4_pkg::IHL_MIN)
        begin
            st = ipv4l4_pkg::ST_IHL_SMALL;
        end
        else if (count < ipv4l4_pkg::COUNT_MIN || count != tlen_ext)
        begin
            st = ipv4l4_pkg::ST_LEN_MISMATCH;
        end
        else if (proto_next == ipv4l4_pkg::PROTO_TCP)
        begin
            rsport_next = ports_next[31:16];
            rdport_next = ports_next[15:0];
            rl4_next    = l4len;
            rflags_next = offfl_next[7:0];
            rpay_next   = tlen_ext - tcp_need;
            if (tlen_ext < tcp_min)
            begin
                st = ipv4l4_pkg::ST_TCP_SHORT;
            end
            else if (tlen_ext < tcp_need)
            begin
                st = ipv4l4_pkg::ST_TCP_NEG;
            end
        end
        else if (proto_next == ipv4l4_pkg::PROTO_UDP)
        begin
            rsport_next = ports_next[31:16];
            rdport_next = ports_next[15:0];
            rpay_next   = tlen_ext - udp_min;
            if (tlen_ext < udp_min)
            begin
                st = ipv4l4_pkg::ST_UDP_SHORT;
            end
        end

        if (st == ipv4l4_pkg::ST_NOT_V4 || st == ipv4l4_pkg::ST_IHL_SMALL
            || st == ipv4l4_pkg::ST_LEN_MISMATCH)
        begin
            rsrc_next   = 32'd0;
            rdst_next   = 32'd0;
            rproto_next = 8'd0;
            rsport_next = 16'd0;
            rdport_next = 16'd0;
            rpay_next   = 17'd0;
            rihl_next   = 6'd0;
            rl4_next    = 6'd0;
            rflags_next = 8'd0;
        end
        status_next = st;

        rvalid_next = rvalid_reg && result_stall;
        if (finish)
        begin
            rvalid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            vihl_reg   <= '0;
            tlen_reg   <= '0;
            proto_reg  <= '0;
            src_reg    <= '0;
            dst_reg    <= '0;
            ports_reg  <= '0;
            offfl_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            rvalid_reg <= rvalid_next;
            if (finish)
            begin
                // clear capture for the next packet
                pos_reg   <= '0;
                vihl_reg  <= '0;
                tlen_reg  <= '0;
                proto_reg <= '0;
                src_reg   <= '0;
                dst_reg   <= '0;
                ports_reg <= '0;
                offfl_reg <= '0;
            end
            else if (take)
            begin
                pos_reg   <= pos_next;
                vihl_reg  <= vihl_next;
                tlen_reg  <= tlen_next;
                proto_reg <= proto_next;
                src_reg   <= src_next;
                dst_reg   <= dst_next;
                ports_reg <= ports_next;
                offfl_reg <= offfl_next;
            end
        end
    end

    // Hold the result while stalled
    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            status_reg <= status_next;
            rsrc_reg   <= rsrc_next;
            rdst_reg   <= rdst_next;
            rproto_reg <= rproto_next;
            rsport_reg <= rsport_next;
            rdport_reg <= rdport_next;
            rpay_reg   <= rpay_next;
            rihl_reg   <= rihl_next;
            rl4_reg    <= rl4_next;
            rflags_reg <= rflags_next;
        end
    end

    assign result_valid     = rvalid_reg;
    assign status           = status_reg;
    assign source_address   = rsrc_reg;
    assign dest_address     = rdst_reg;
    assign protocol_number  = rproto_reg;
    assign source_port      = rsport_reg;
    assign dest_port        = rdport_reg;
    assign payload_length   = rpay_reg;
    assign ip_header_length = rihl_reg;
    assign l4_header_length = rl4_reg;
    assign tcp_flag_bits    = rflags_reg;

endmodule

`default_nettype wire

### tb/sv/ipv4_l4_header_parser_core_tb.sv
// Testbench for ipv4_l4_header_parser_core: byte-stream packets in, one header summary out.
// Predicts each summary from the bytes sent and checks it field by field.
// Depends on ipv4l4_pkg and the core RTL.
module ipv4_l4_header_parser_core_tb;

    localparam int LIMIT_CYCLES   = 1000000;
    localparam int HOLD_CYCLES    = 300;
    localparam int RANDOM_BYTES   = 100;
    localparam int RANDOM_PACKETS = 3;

    typedef struct packed {
        ipv4l4_pkg::status_t status;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [7:0]  proto;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [16:0] payload_len;
        logic [5:0]  ip_hdr_len;
        logic [5:0]  l4_hdr_len;
        logic [7:0]  flags;
    } header_summary_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        data_valid = 1'b0;
    logic        data_stall;
    logic [7:0]  data_byte = 8'd0;
    logic        end_of_packet = 1'b0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [2:0]  status;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [7:0]  protocol_number;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [16:0] payload_length;
    logic [5:0]  ip_header_length;
    logic [5:0]  l4_header_length;
    logic [7:0]  tcp_flag_bits;

    // Parser state as seen by the predictor.
    logic [15:0] byte_pos = '0;
    logic [7:0]  ver_ihl_byte = '0;
    logic [15:0] len_field = '0;
    logic [7:0]  proto_byte = '0;
    logic [31:0] src_word = '0;
    logic [31:0] dst_word = '0;
    logic [31:0] port_pair = '0;
    logic [15:0] doff_flags = '0;

    header_summary_t expected_summaries[$];
    int              mismatch_count = 0;
    bit              idle_enable = 1'b1;
    bit              hold_pending = 1'b0;

    ipv4_l4_header_parser_core i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .data_valid       (data_valid),
        .data_stall       (data_stall),
        .data_byte        (data_byte),
        .end_of_packet    (end_of_packet),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .status           (status),
        .source_address   (source_address),
        .dest_address     (dest_address),
        .protocol_number  (protocol_number),
        .source_port      (source_port),
        .dest_port        (dest_port),
        .payload_length   (payload_length),
        .ip_header_length (ip_header_length),
        .l4_header_length (l4_header_length),
        .tcp_flag_bits    (tcp_flag_bits)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_enable || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void predict_byte(input logic [7:0] b, input logic eop);
        int unsigned     p;
        int unsigned     off;
        int unsigned     count;
        int unsigned     l4len;
        int unsigned     payload;
        header_summary_t r;
        p = byte_pos;
        if (p == ipv4l4_pkg::POS_VER_IHL)
            ver_ihl_byte = b;
        if (p == ipv4l4_pkg::POS_LEN_HI)
            len_field[15:8] = b;
        if (p == ipv4l4_pkg::POS_LEN_LO)
            len_field[7:0] = b;
        if (p == ipv4l4_pkg::POS_PROTO)
            proto_byte = b;
        if (p >= ipv4l4_pkg::POS_SRC_FIRST && p <= ipv4l4_pkg::POS_SRC_LAST)
            src_word[8 * (ipv4l4_pkg::POS_SRC_LAST - p) +: 8] = b;
        if (p >= ipv4l4_pkg::POS_DST_FIRST && p <= ipv4l4_pkg::POS_DST_LAST)
            dst_word[8 * (ipv4l4_pkg::POS_DST_LAST - p) +: 8] = b;
        off = ver_ihl_byte[3:0] * 4;
        if (p >= off && p < off + ipv4l4_pkg::L4_PORT_BYTES)
            port_pair[8 * (3 - (p - off)) +: 8] = b;
        if (p == off + ipv4l4_pkg::L4_OFF_BYTE)
            doff_flags[15:8] = b;
        if (p == off + ipv4l4_pkg::L4_FLAG_BYTE)
            doff_flags[7:0] = b;
        if (p < ipv4l4_pkg::POS_MAX)
            byte_pos = p + 1;
        if (!eop)
            return;

        count = p + 1;
        l4len = 0;
        payload = len_field - off;
        r = '0;
        r.status = ipv4l4_pkg::ST_OK;
        if (ver_ihl_byte[7:4] != ipv4l4_pkg::IP_VERSION_4)
            r.status = ipv4l4_pkg::ST_NOT_V4;
        else if (ver_ihl_byte[3:0] < ipv4l4_pkg::IHL_MIN)
            r.status = ipv4l4_pkg::ST_IHL_SMALL;
        else if (count < ipv4l4_pkg::COUNT_MIN || count != len_field)
            r.status = ipv4l4_pkg::ST_LEN_MISMATCH;
        else
        begin
            if (proto_byte == ipv4l4_pkg::PROTO_TCP)
            begin
                l4len = doff_flags[15:12] * 4;
                r.src_port = port_pair[31:16];
                r.dst_port = port_pair[15:0];
                r.flags = doff_flags[7:0];
                payload = len_field - off - l4len;
                if (len_field < off + ipv4l4_pkg::TCP_HDR_MIN)
                    r.status = ipv4l4_pkg::ST_TCP_SHORT;
                else if (len_field < off + l4len)
                    r.status = ipv4l4_pkg::ST_TCP_NEG;
            end
            else if (proto_byte == ipv4l4_pkg::PROTO_UDP)
            begin
                r.src_port = port_pair[31:16];
                r.dst_port = port_pair[15:0];
                payload = len_field - off - ipv4l4_pkg::UDP_HDR_LEN;
                if (len_field < off + ipv4l4_pkg::UDP_HDR_LEN)
                    r.status = ipv4l4_pkg::ST_UDP_SHORT;
            end
            r.src_addr = src_word;
            r.dst_addr = dst_word;
            r.proto = proto_byte;
            r.payload_len = payload[16:0];
            r.ip_hdr_len = off[5:0];
            r.l4_hdr_len = l4len[5:0];
        end
        expected_summaries.push_back(r);

        byte_pos = '0;
        ver_ihl_byte = '0;
        len_field = '0;
        proto_byte = '0;
        src_word = '0;
        dst_word = '0;
        port_pair = '0;
        doff_flags = '0;
    endfunction

    // Header of at least 20 bytes, transport bytes, payload; random content; cut_to trims.
    function automatic void build_packet(ref logic [7:0] pkt[$], input logic [7:0] ver_ihl,
                                         input logic [7:0] proto, input int l4_bytes,
                                         input logic [3:0] doff, input int payload_bytes,
                                         input int len_adjust, input int cut_to);
        int          hdr_bytes;
        logic [15:0] total;
        hdr_bytes = (ver_ihl[3:0] < ipv4l4_pkg::IHL_MIN) ? 20 : ver_ihl[3:0] * 4;
        pkt.delete();
        repeat (hdr_bytes + l4_bytes + payload_bytes)
            pkt.push_back(8'($urandom));
        total = 16'(pkt.size() + len_adjust);
        pkt[0] = ver_ihl;
        pkt[2] = total[15:8];
        pkt[3] = total[7:0];
        pkt[9] = proto;
        if (l4_bytes > 12)
            pkt[hdr_bytes + 12] = {doff, pkt[hdr_bytes + 12][3:0]};
        while (cut_to > 0 && pkt.size() > cut_to)
            void'(pkt.pop_back());
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic eop);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            data_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        data_valid <= 1'b1;
        data_byte <= b;
        end_of_packet <= eop;
        @(posedge clk);
        while (data_stall)
            @(posedge clk);
        predict_byte(b, eop);
    endtask

    task automatic send_packet(input logic [7:0] pkt[$]);
        foreach (pkt[i])
            send_byte(pkt[i], i == pkt.size() - 1);
    endtask

    task automatic test_field_extremes();
        logic [7:0] pkt[$];
        build_packet(pkt, 8'h4F, ipv4l4_pkg::PROTO_TCP, 60, 4'hF, 0, 0, 0);
        for (int i = 12; i < 20; i++)
            pkt[i] = 8'hFF;
        for (int i = 60; i < 64; i++)
            pkt[i] = 8'hFF;
        pkt[72] = 8'hFF;
        pkt[73] = 8'hFF;
        send_packet(pkt);
        build_packet(pkt, 8'h45, ipv4l4_pkg::PROTO_UDP, 8, 4'h0, 3, 0, 0);
        for (int i = 12; i < 24; i++)
            pkt[i] = 8'h00;
        send_packet(pkt);
        build_packet(pkt, 8'h45, 8'hFF, 0, 4'h0, 5, 0, 0);
        send_packet(pkt);
        build_packet(pkt, 8'h45, 8'h00, 4, 4'h0, 0, 0, 0);
        send_packet(pkt);
        build_packet(pkt, 8'h45, ipv4l4_pkg::PROTO_TCP, 20, 4'h5, 0, 0, 0);
        pkt[33] = 8'h00;
        send_packet(pkt);
    endtask

    task automatic test_header_rejects();
        logic [7:0] pkt[$];
        build_packet(pkt, 8'h05, ipv4l4_pkg::PROTO_TCP, 20, 4'h5, 2, 0, 0);
        send_packet(pkt);
        build_packet(pkt, 8'hF5, ipv4l4_pkg::PROTO_UDP, 8, 4'h0, 2, 0, 0);
        send_packet(pkt);
        build_packet(pkt, 8'h65, ipv4l4_pkg::PROTO_TCP, 20, 4'h5, 0, 0, 0);
        send_packet(pkt);
        build_packet(pkt, 8'h40, ipv4l4_pkg::PROTO_TCP, 20, 4'h5, 0, 0, 0);
        send_packet(pkt);
        build_packet(pkt, 8'h44, ipv4l4_pkg::PROTO_UDP, 8, 4'h0, 1, 0, 0);
        send_packet(pkt);
        build_packet(pkt, 8'h45, ipv4l4_pkg::PROTO_TCP, 20, 4'h5, 4, 1, 0);
        send_packet(pkt);
        build_packet(pkt, 8'h45, ipv4l4_pkg::PROTO_UDP, 8, 4'h0, 4, -1, 0);
        send_packet(pkt);
        for (int n = 1; n <= 3; n++)
        begin
            build_packet(pkt, 8'h45, ipv4l4_pkg::PROTO_TCP, 0, 4'h0, 0, n - 20, n);
            send_packet(pkt);
        end
        build_packet(pkt, 8'h45, 8'h00, 0, 4'h0, 0, -16, 4);
        send_packet(pkt);
    endtask

    task automatic test_transport_errors();
        logic [7:0] pkt[$];
        build_packet(pkt, 8'h45, ipv4l4_pkg::PROTO_TCP, 14, 4'h5, 0, 0, 0);
        send_packet(pkt);
        build_packet(pkt, 8'h47, ipv4l4_pkg::PROTO_TCP, 19, 4'h5, 0, 0, 0);
        send_packet(pkt);
        build_packet(pkt, 8'h45, ipv4l4_pkg::PROTO_TCP, 20, 4'hF, 0, 0, 0);
        send_packet(pkt);
        build_packet(pkt, 8'h45, ipv4l4_pkg::PROTO_TCP, 20, 4'h6, 3, 0, 0);
        send_packet(pkt);
        build_packet(pkt, 8'h45, ipv4l4_pkg::PROTO_TCP, 20, 4'h6, 4, 0, 0);
        send_packet(pkt);
        build_packet(pkt, 8'h45, ipv4l4_pkg::PROTO_TCP, 20, 4'h2, 1, 0, 0);
        send_packet(pkt);
        build_packet(pkt, 8'h45, ipv4l4_pkg::PROTO_UDP, 7, 4'h0, 0, 0, 0);
        send_packet(pkt);
        build_packet(pkt, 8'h45, ipv4l4_pkg::PROTO_UDP, 8, 4'h0, 0, 0, 0);
        send_packet(pkt);
        build_packet(pkt, 8'h45, ipv4l4_pkg::PROTO_UDP, 4, 4'h0, 0, 0, 0);
        send_packet(pkt);
        build_packet(pkt, 8'h45, ipv4l4_pkg::PROTO_TCP, 0, 4'h0, 0, -10, 10);
        send_packet(pkt);
    endtask

    task automatic test_backpressure();
        logic [7:0] pkt[$];
        idle_enable = 1'b0;
        hold_pending = 1'b1;
        repeat (4)
        begin
            build_packet(pkt, 8'h45, 8'h01, 0, 4'h0, $urandom_range(0, 2), 0, 0);
            send_packet(pkt);
        end
        while (hold_pending)
            @(posedge clk);
        idle_enable = 1'b1;
    endtask

    task automatic test_random_packets();
        logic [7:0] pkt[$];
        logic [7:0] proto;
        logic [7:0] v4_ihl;
        int         sent_bytes;
        int         packets;
        int         kind;
        int         ihl;
        int         doff;
        sent_bytes = 0;
        packets = 0;
        while (sent_bytes < RANDOM_BYTES || packets < RANDOM_PACKETS)
        begin
            idle_enable = ($urandom_range(0, 4) != 0);
            kind = $urandom_range(0, 99);
            ihl = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 15) : 5;
            doff = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 15) : 5;
            v4_ihl = {ipv4l4_pkg::IP_VERSION_4, 4'(ihl)};
            proto = ($urandom_range(0, 2) == 0) ? ipv4l4_pkg::PROTO_TCP
                  : ($urandom_range(0, 1) ? ipv4l4_pkg::PROTO_UDP : 8'($urandom));
            if (kind < 45)
                build_packet(pkt, v4_ihl, ipv4l4_pkg::PROTO_TCP, doff * 4, 4'(doff),
                             $urandom_range(0, 8), 0, 0);
            else if (kind < 68)
                build_packet(pkt, v4_ihl, ipv4l4_pkg::PROTO_UDP, 8, 4'($urandom),
                             $urandom_range(0, 8), 0, 0);
            else if (kind < 76)
                build_packet(pkt, v4_ihl, 8'($urandom), $urandom_range(0, 16),
                             4'($urandom), $urandom_range(0, 8), 0, 0);
            else
                build_packet(pkt, $urandom_range(0, 1) ? 8'($urandom) : 8'h45, proto,
                             $urandom_range(0, 24), 4'($urandom), $urandom_range(0, 8),
                             ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, 4)) - 2 : 0,
                             ($urandom_range(0, 2) == 0) ? int'($urandom_range(1, 30)) : 0);
            send_packet(pkt);
            sent_bytes += pkt.size();
            packets++;
        end
        idle_enable = 1'b1;
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin : check_summaries
        header_summary_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_summaries.size() == 0)
            begin
                $display("%0t: unexpected transfer, expected none, actual status %0h",
                         $time, status);
                mismatch_count++;
            end
            else
            begin
                want = expected_summaries.pop_front();
                check_field("status", want.status, status);
                check_field("source_address", want.src_addr, source_address);
                check_field("dest_address", want.dst_addr, dest_address);
                check_field("protocol_number", want.proto, protocol_number);
                check_field("source_port", want.src_port, source_port);
                check_field("dest_port", want.dst_port, dest_port);
                check_field("payload_length", want.payload_len, payload_length);
                check_field("ip_header_length", want.ip_hdr_len, ip_header_length);
                check_field("l4_header_length", want.l4_hdr_len, l4_header_length);
                check_field("tcp_flag_bits", want.flags, tcp_flag_bits);
            end
        end
    end

    initial
    begin : result_drain
        int n;
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                result_stall <= 1'b0;
                hold_pending = 1'b0;
            end
            else
            begin
                n = pick_gap();
                if (n > 0)
                begin
                    result_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                    result_stall <= 1'b0;
                end
            end
        end
    end

    initial
    begin
        #(2 * LIMIT_CYCLES);
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_field_extremes();
        test_header_rejects();
        test_transport_errors();
        test_backpressure();
        test_random_packets();
        data_valid <= 1'b0;
        end_of_packet <= 1'b0;
        while (expected_summaries.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
